FILE: hw/rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the rtl
// expects aclk in the scope of each use, and aresetn as well for CSC_ASSERT
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define CSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked check that also holds across reset
`define CSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hw/rtl/csc_pkg.sv
// csc_pkg: types shared by the circle/segment collision datapath
// no dependencies
package csc_pkg;

    // how the projection parameter t is formed
    typedef enum logic [1:0] {
        TSEL_DIV,
        TSEL_ZERO,
        TSEL_ONE
    } csc_tsel_t;

    // result flags, contact in the lowest bit
    typedef struct packed {
        logic degen;
        logic contact;
    } csc_flags_t;

endpackage

FILE: hw/rtl/csc_div_pipe.sv
// csc_div_pipe: pipelined restoring divider, one quotient bit per stage
// quo = floor(num * 2^(QW-1) / den), valid when num < 2 * den; no dependencies
module csc_div_pipe #(
    parameter int DW = 34,
    parameter int QW = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];
    logic [DW:0]   sh_in    [QW];
    logic [DW-1:0] den_in   [QW];
    logic [QW-1:0] quo_in   [QW];
    logic          ge       [QW];

    always_comb begin
        sh_in[0]  = {1'b0, num};
        den_in[0] = den;
        quo_in[0] = '0;
        for (int k = 1; k < QW; k++) begin
            sh_in[k]  = {rem_reg[k-1], 1'b0};
            den_in[k] = den_reg[k-1];
            quo_in[k] = quo_reg[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            ge[k] = sh_in[k] >= {1'b0, den_in[k]};
            if (ge[k]) begin
                rem_next[k] = DW'(sh_in[k] - {1'b0, den_in[k]});
            end else begin
                rem_next[k] = DW'(sh_in[k]);
            end
            quo_next[k] = {quo_in[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

FILE: hw/rtl/circle_segment_collision.sv
// circle_segment_collision: ball against line segment, push-out and velocity reflection
// depends on csc_pkg, csc_div_pipe and assert_macros.svh
//
//  channel | dir | tdata (lowest bit up)                                | tuser
//  s_      | in  | ball_x ball_y vel_x vel_y radius seg_ax seg_ay       | -
//          |     | seg_bx seg_by, zero padded to bytes                  |
//  m_      | out | new_x new_y new_vx new_vy, zero padded to bytes      | contact degenerate
//
// one request enters per cycle while the output is not stalled; the pipeline length
// is set by the t divider, the square root and the normal divider, each of which
// resolves one bit per stage
// the whole pipeline advances together whenever the output register is empty or taken;
// a stalled output freezes every stage, so nothing is lost or repeated
// reset clears only the valid bits, the datapath registers are not reset
`include "assert_macros.svh"

module circle_segment_collision #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // ball_x, ball_y, vel_x, vel_y, radius, seg_ax, seg_ay, seg_bx, seg_by
    input  logic [((9*COORD_WIDTH-1+7)/8)*8-1:0]          s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // new_x, new_y, new_vx, new_vy
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]            m_tdata,
    // contact, degenerate
    output logic [1:0]                                   m_tuser
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LQ   = F + 1;           // quotient bits of all three dividers
    localparam int D    = W + 2;           // square root result bits
    localparam int SQW  = 2 * W + 4;       // squared distance and root remainder
    localparam int DENW = 2 * W + 2;
    localparam int NXW  = W + 2;
    localparam int OFFW = W + F + 3;
    localparam int UW   = F + 2;
    localparam int MPW  = W + F + 2;
    localparam int MVW  = W + 2;
    localparam int DV2W = W + 3;
    localparam int WPW  = W + F + 5;
    localparam int SATW = W + 4;
    localparam int CW   = 5 * W - 1;
    localparam int GW   = 4 * (W + 1);
    localparam int M_W  = ((4 * W + 7) / 8) * 8;

    // stage indices
    localparam int S5  = 4 + LQ;
    localparam int S7  = S5 + 2;
    localparam int S10 = S5 + 5;
    localparam int S11 = S10 + 1 + D;
    localparam int S12 = S11 + 1 + LQ;
    localparam int S15 = S12 + 3;
    localparam int L   = S15 + 2;
    localparam int GEO_N = 6 + LQ;
    localparam int NXY_N = 4 + D;
    localparam int FL_N  = S15 - S10 + 1;
    localparam int SG_N  = LQ + 1;
    localparam int PEN_N = LQ + 2;
    localparam int CAR_N = S15 + 1;

    localparam logic [LQ-1:0] ONE_T = {1'b1, {F{1'b0}}};

    // ---------------------------------------------------------------- control
    logic         en;
    logic [L-1:0] vld_reg;
    logic [L-1:0] vld_next;

    assign en       = !vld_reg[L-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[L-1];
    assign vld_next = {vld_reg[L-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------- input unpack
    logic [W-1:0]   in_ax, in_ay, in_bx, in_by, in_x, in_y;
    logic [CW-1:0]  carry_next;
    logic [GW-1:0]  geo_next;
    logic [W:0]     dx_next, dy_next, px_next, py_next;

    assign in_x  = s_tdata[W-1:0];
    assign in_y  = s_tdata[2*W-1:W];
    assign in_ax = s_tdata[6*W-2:5*W-1];
    assign in_ay = s_tdata[7*W-2:6*W-1];
    assign in_bx = s_tdata[8*W-2:7*W-1];
    assign in_by = s_tdata[9*W-2:8*W-1];
    // x, y, vx, vy, radius from the lowest bit up
    assign carry_next = s_tdata[CW-1:0];

    assign dx_next  = {in_bx[W-1], in_bx} - {in_ax[W-1], in_ax};
    assign dy_next  = {in_by[W-1], in_by} - {in_ay[W-1], in_ay};
    assign px_next  = {in_x[W-1], in_x} - {in_ax[W-1], in_ax};
    assign py_next  = {in_y[W-1], in_y} - {in_ay[W-1], in_ay};
    assign geo_next = {py_next, px_next, dy_next, dx_next};

    // shift lines that ride alongside the datapath
    logic [CW-1:0]  carry_reg [CAR_N];
    logic [GW-1:0]  geo_reg   [GEO_N];

    // field views of the side lines
    function automatic logic signed [W:0] geo_f(input logic [GW-1:0] g, input int idx);
        geo_f = $signed(g[idx*(W+1) +: (W+1)]);
    endfunction

    function automatic logic signed [W-1:0] car_f(input logic [CW-1:0] c, input int idx);
        car_f = $signed(c[idx*W +: W]);
    endfunction

    function automatic logic [W-2:0] car_r(input logic [CW-1:0] c);
        car_r = c[CW-1:4*W];
    endfunction

    function automatic logic [W-1:0] sat_w(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] hi;
        logic signed [SATW-1:0] lo;
        hi = $signed({{(SATW-W+1){1'b0}}, {(W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            sat_w = {1'b0, {(W-1){1'b1}}};
        end else if (v < lo) begin
            sat_w = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_w = v[W-1:0];
        end
    endfunction

    // ---------------------------------------------------------------- s2..s4: dot products
    logic signed [2*W+1:0] pdx_reg, pdy_reg, pnx_reg, pny_reg;
    logic [DENW-1:0]       den_reg;
    logic signed [DENW-1:0] num_reg;
    csc_pkg::csc_tsel_t    tsel_next;
    csc_pkg::csc_tsel_t    tsel_reg [LQ+1];
    logic [DENW-1:0]       dnum_reg, dden_reg;
    logic [LQ-1:0]         quo_t;

    // zero-length segment or centre behind A gives t = 0, beyond B gives t = 1
    always_comb begin
        priority if (den_reg == '0 || num_reg[DENW-1] || num_reg == '0) begin
            tsel_next = csc_pkg::TSEL_ZERO;
        end else if ($unsigned(num_reg) >= den_reg) begin
            tsel_next = csc_pkg::TSEL_ONE;
        end else begin
            tsel_next = csc_pkg::TSEL_DIV;
        end
    end

    csc_div_pipe #(.DW(DENW), .QW(LQ)) u_div_t (
        .aclk (aclk),
        .en   (en),
        .num  (dnum_reg),
        .den  (dden_reg),
        .quo  (quo_t)
    );

    // ---------------------------------------------------------------- s5..s10: nearest point, distance
    logic [LQ-1:0]          t_next, t_reg;
    logic signed [OFFW-1:0] offx_reg, offy_reg;
    logic signed [OFFW-1:0] offx_sh, offy_sh;
    logic signed [NXW-1:0]  nx_next, ny_next;
    logic [2*NXW-1:0]       nxy_reg [NXY_N];
    logic signed [2*NXW-1:0] sqx_reg, sqy_reg;
    logic [2*W-3:0]         rr_reg, rr9_reg;
    logic [SQW-1:0]         ss9_reg, ss10_reg;
    csc_pkg::csc_flags_t    fl_next;
    csc_pkg::csc_flags_t    fl_reg [FL_N];

    // selector delayed to line up with the divider output
    always_comb begin
        unique case (tsel_reg[LQ])
            csc_pkg::TSEL_ZERO: t_next = '0;
            csc_pkg::TSEL_ONE:  t_next = ONE_T;
            csc_pkg::TSEL_DIV:  t_next = quo_t;
            default:            t_next = '0;
        endcase
    end

    assign offx_sh = offx_reg >>> F;
    assign offy_sh = offy_reg >>> F;
    assign nx_next = NXW'(offx_sh) - NXW'(geo_f(geo_reg[GEO_N-1], 2));
    assign ny_next = NXW'(offy_sh) - NXW'(geo_f(geo_reg[GEO_N-1], 3));

    assign fl_next.contact = ss9_reg <= SQW'(rr9_reg);
    assign fl_next.degen   = (ss9_reg <= SQW'(rr9_reg)) && (ss9_reg == '0);

    // ---------------------------------------------------------------- square root, one bit a stage
    logic [SQW-1:0] sq_rem_reg  [D];
    logic [D-1:0]   sq_res_reg  [D];
    logic [SQW-1:0] sq_rem_next [D];
    logic [D-1:0]   sq_res_next [D];
    logic [SQW-1:0] sq_rin      [D];
    logic [D-1:0]   sq_qin      [D];
    logic [SQW-1:0] sq_trial    [D];

    always_comb begin
        sq_rin[0] = ss10_reg;
        sq_qin[0] = '0;
        for (int k = 1; k < D; k++) begin
            sq_rin[k] = sq_rem_reg[k-1];
            sq_qin[k] = sq_res_reg[k-1];
        end
        for (int k = 0; k < D; k++) begin
            // (q + 2^b)^2 - q^2 = q * 2^(b+1) + 2^(2b)
            sq_trial[k] = (SQW'(sq_qin[k]) << (D - k)) + (SQW'(1) << (2 * (D - 1 - k)));
            if (sq_rin[k] >= sq_trial[k]) begin
                sq_rem_next[k] = sq_rin[k] - sq_trial[k];
                sq_res_next[k] = sq_qin[k] | (D'(1) << (D - 1 - k));
            end else begin
                sq_rem_next[k] = sq_rin[k];
                sq_res_next[k] = sq_qin[k];
            end
        end
    end

    // ---------------------------------------------------------------- s11..s12: unit normal
    logic [D-1:0]          d11_reg;
    logic [NXW-1:0]        ax11_reg, ay11_reg;
    logic signed [NXW-1:0] nx_sq, ny_sq;
    logic [W-2:0]          pen_next;
    logic [W-2:0]          pen_reg [PEN_N];
    logic [1:0]            sg_reg  [SG_N];
    logic [LQ-1:0]         quo_ux, quo_uy, qcx, qcy;
    logic signed [UW-1:0]  ux_next, uy_next, ux_reg, uy_reg;

    assign nx_sq    = $signed(nxy_reg[NXY_N-1][NXW-1:0]);
    assign ny_sq    = $signed(nxy_reg[NXY_N-1][2*NXW-1:NXW]);
    assign pen_next = car_r(carry_reg[S11-1]) - (W-1)'(sq_res_reg[D-1]);

    csc_div_pipe #(.DW(D), .QW(LQ)) u_div_ux (
        .aclk (aclk),
        .en   (en),
        .num  (ax11_reg),
        .den  (d11_reg),
        .quo  (quo_ux)
    );

    csc_div_pipe #(.DW(D), .QW(LQ)) u_div_uy (
        .aclk (aclk),
        .en   (en),
        .num  (ay11_reg),
        .den  (d11_reg),
        .quo  (quo_uy)
    );

    // each part clamped to +-1.0, sign restored after the magnitude divide
    assign qcx     = (quo_ux > ONE_T) ? ONE_T : quo_ux;
    assign qcy     = (quo_uy > ONE_T) ? ONE_T : quo_uy;
    assign ux_next = sg_reg[SG_N-1][0] ? -$signed({1'b0, qcx}) : $signed({1'b0, qcx});
    assign uy_next = sg_reg[SG_N-1][1] ? -$signed({1'b0, qcy}) : $signed({1'b0, qcy});

    // ---------------------------------------------------------------- s13..s16: response
    logic signed [MPW-1:0]  pux_reg, puy_reg, pvx_reg, pvy_reg;
    logic signed [UW-1:0]   ux13_reg, uy13_reg, ux14_reg, uy14_reg;
    logic signed [MVW-1:0]  mvx_reg, mvy_reg, mvx15_reg, mvy15_reg;
    logic signed [MPW:0]    dvs_reg, dvs_sh;
    logic signed [DV2W-1:0] dv2;
    logic signed [WPW-1:0]  wx_reg, wy_reg;
    logic signed [MPW-1:0]  pux_sh, puy_sh;
    logic signed [WPW-1:0]  wx_sh, wy_sh;
    logic signed [SATW-1:0] npx_full, npy_full, nvx_full, nvy_full;
    logic                   apply;
    logic [W-1:0]           out_x_next, out_y_next, out_vx_next, out_vy_next;
    logic [W-1:0]           out_x_reg, out_y_reg, out_vx_reg, out_vy_reg;
    csc_pkg::csc_flags_t    out_fl_reg;

    assign pux_sh = pux_reg >>> F;
    assign puy_sh = puy_reg >>> F;
    assign dvs_sh = dvs_reg >>> F;
    assign dv2    = $signed({dvs_sh[W+1:0], 1'b0});
    assign wx_sh  = wx_reg >>> F;
    assign wy_sh  = wy_reg >>> F;

    assign npx_full = SATW'(car_f(carry_reg[S15], 0)) - SATW'(mvx15_reg);
    assign npy_full = SATW'(car_f(carry_reg[S15], 1)) - SATW'(mvy15_reg);
    assign nvx_full = SATW'(car_f(carry_reg[S15], 2)) - SATW'(wx_sh);
    assign nvy_full = SATW'(car_f(carry_reg[S15], 3)) - SATW'(wy_sh);

    // no contact or centre exactly on the segment: ball passes unchanged
    assign apply = fl_reg[FL_N-1].contact && !fl_reg[FL_N-1].degen;

    always_comb begin
        if (apply) begin
            out_x_next  = sat_w(npx_full);
            out_y_next  = sat_w(npy_full);
            out_vx_next = sat_w(nvx_full);
            out_vy_next = sat_w(nvy_full);
        end else begin
            out_x_next  = carry_reg[S15][W-1:0];
            out_y_next  = carry_reg[S15][2*W-1:W];
            out_vx_next = carry_reg[S15][3*W-1:2*W];
            out_vy_next = carry_reg[S15][4*W-1:3*W];
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            carry_reg[0] <= carry_next;
            for (int i = 1; i < CAR_N; i++) carry_reg[i] <= carry_reg[i-1];
            geo_reg[0] <= geo_next;
            for (int i = 1; i < GEO_N; i++) geo_reg[i] <= geo_reg[i-1];

            // s2
            pdx_reg <= geo_f(geo_reg[0], 0) * geo_f(geo_reg[0], 0);
            pdy_reg <= geo_f(geo_reg[0], 1) * geo_f(geo_reg[0], 1);
            pnx_reg <= geo_f(geo_reg[0], 2) * geo_f(geo_reg[0], 0);
            pny_reg <= geo_f(geo_reg[0], 3) * geo_f(geo_reg[0], 1);
            // s3
            den_reg <= $unsigned(pdx_reg) + $unsigned(pdy_reg);
            num_reg <= pnx_reg + pny_reg;
            // s4
            tsel_reg[0] <= tsel_next;
            for (int i = 1; i <= LQ; i++) tsel_reg[i] <= tsel_reg[i-1];
            dnum_reg <= $unsigned(num_reg);
            dden_reg <= den_reg;
            // s5, s6
            t_reg    <= t_next;
            offx_reg <= geo_f(geo_reg[S5], 0) * $signed({1'b0, t_reg});
            offy_reg <= geo_f(geo_reg[S5], 1) * $signed({1'b0, t_reg});
            // s7
            nxy_reg[0] <= {ny_next, nx_next};
            for (int i = 1; i < NXY_N; i++) nxy_reg[i] <= nxy_reg[i-1];
            // s8, s9
            sqx_reg <= $signed(nxy_reg[0][NXW-1:0]) * $signed(nxy_reg[0][NXW-1:0]);
            sqy_reg <= $signed(nxy_reg[0][2*NXW-1:NXW]) * $signed(nxy_reg[0][2*NXW-1:NXW]);
            rr_reg  <= car_r(carry_reg[S7]) * car_r(carry_reg[S7]);
            ss9_reg <= $unsigned(sqx_reg) + $unsigned(sqy_reg);
            rr9_reg <= rr_reg;
            // s10
            ss10_reg  <= ss9_reg;
            fl_reg[0] <= fl_next;
            for (int i = 1; i < FL_N; i++) fl_reg[i] <= fl_reg[i-1];
            // square root stages
            for (int k = 0; k < D; k++) begin
                sq_rem_reg[k] <= sq_rem_next[k];
                sq_res_reg[k] <= sq_res_next[k];
            end
            // s11
            d11_reg    <= sq_res_reg[D-1];
            ax11_reg   <= nx_sq[NXW-1] ? NXW'(-nx_sq) : NXW'(nx_sq);
            ay11_reg   <= ny_sq[NXW-1] ? NXW'(-ny_sq) : NXW'(ny_sq);
            pen_reg[0] <= pen_next;
            for (int i = 1; i < PEN_N; i++) pen_reg[i] <= pen_reg[i-1];
            sg_reg[0]  <= {ny_sq[NXW-1], nx_sq[NXW-1]};
            for (int i = 1; i < SG_N; i++) sg_reg[i] <= sg_reg[i-1];
            // s12
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            // s13
            pux_reg  <= ux_reg * $signed({1'b0, pen_reg[PEN_N-1]});
            puy_reg  <= uy_reg * $signed({1'b0, pen_reg[PEN_N-1]});
            pvx_reg  <= car_f(carry_reg[S12], 2) * ux_reg;
            pvy_reg  <= car_f(carry_reg[S12], 3) * uy_reg;
            ux13_reg <= ux_reg;
            uy13_reg <= uy_reg;
            // s14
            mvx_reg  <= MVW'(pux_sh);
            mvy_reg  <= MVW'(puy_sh);
            dvs_reg  <= (MPW+1)'(pvx_reg) + (MPW+1)'(pvy_reg);
            ux14_reg <= ux13_reg;
            uy14_reg <= uy13_reg;
            // s15
            wx_reg    <= ux14_reg * dv2;
            wy_reg    <= uy14_reg * dv2;
            mvx15_reg <= mvx_reg;
            mvy15_reg <= mvy_reg;
            // s16, output register
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_vx_reg <= out_vx_next;
            out_vy_reg <= out_vy_next;
            out_fl_reg <= fl_reg[FL_N-1];
        end
    end

    assign m_tdata = M_W'({out_vy_reg, out_vx_reg, out_y_reg, out_x_reg});
    assign m_tuser = out_fl_reg;

    // ---------------------------------------------------------------- checks
    `CSC_ASSERT(a_t_in_range, vld_reg[S5] |-> (t_reg <= ONE_T), "projection t above one")
    `CSC_ASSERT(a_root_below_radius, (vld_reg[S11] && fl_reg[S11-S10].contact) |-> (d11_reg <= D'(car_r(carry_reg[S11]))), "distance above radius on contact")
    `CSC_ASSERT(a_degen_needs_contact, (m_tvalid && out_fl_reg.degen) |-> out_fl_reg.contact, "degenerate flag without contact")
    `CSC_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid, "result valid straight after reset")

endmodule
